// ----- hw/rtl/fbp_pkg.sv -----
// Shared types and constants for the free-list buffer pool.
package fbp_pkg;

  // Pool geometry
  localparam int POOL_DEPTH = 256;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int ADDR_W     = 32;
  localparam int STRIDE_W   = 16;
  localparam int COUNT_W    = 9;
  localparam int PROD_W     = IDX_W + STRIDE_W;
  localparam int DIV_CNT_W  = $clog2(ADDR_W);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

  // Register reset values
  localparam logic [ADDR_W-1:0]   BASE_RST   = '0;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd8;
  localparam logic [COUNT_W-1:0]  COUNT_RST  = 9'd256;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_REBUILD = 2'd2,
    KIND_NOP     = 2'd3
  } fbp_kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_NOT_ELEMENT = 2'd2
  } fbp_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_DIV,
    S_FREE,
    S_REBUILD,
    S_DONE
  } fbp_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic res_empty;
    logic alloc_read;
    logic alloc_commit;
    logic res_bad;
    logic div_start;
    logic div_step;
    logic free_commit;
    logic rb_start;
    logic rb_step;
    logic res_ok;
    logic out_load;
  } fbp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    fbp_kind_t kind;
    logic      free_zero;
    logic      addr_bad;
    logic      div_last;
    logic      rb_last;
    logic      out_free;
  } fbp_sts_t;

endpackage

// ----- hw/rtl/fbp_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface fbp_in_if import fbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] element_address;

  modport source (output valid, kind, element_address, input ready);
  modport sink   (input valid, kind, element_address, output ready);
endinterface

interface fbp_out_if import fbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] granted_address;
  logic [CNT_W-1:0]  free_elements;

  modport source (output valid, status, granted_address, free_elements, input ready);
  modport sink   (input valid, status, granted_address, free_elements, output ready);
endinterface

// ----- hw/rtl/fbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/fbp_ctrl.sv -----
// Sequencing state machine for allocate, free and rebuild transactions.
module fbp_ctrl import fbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fbp_sts_t  sts,
  output fbp_cmd_t  cmd
);

  fbp_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          KIND_ALLOC: begin
            if (sts.free_zero) begin
              cmd.res_empty = 1'b1;
              state_nxt     = S_DONE;
            end else begin
              cmd.alloc_read = 1'b1;
              state_nxt      = S_ALLOC;
            end
          end
          KIND_FREE: begin
            if (sts.addr_bad) begin
              cmd.res_bad = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          KIND_REBUILD: begin
            cmd.rb_start = 1'b1;
            state_nxt    = S_REBUILD;
          end
          default: begin
            cmd.res_ok = 1'b1;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_ALLOC: begin
        cmd.alloc_commit = 1'b1;
        state_nxt        = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FREE;
        end
      end
      S_FREE: begin
        cmd.free_commit = 1'b1;
        state_nxt       = S_DONE;
      end
      S_REBUILD: begin
        cmd.rb_step = 1'b1;
        if (sts.rb_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Allocate commit always follows the head read issued in decode
  a_alloc_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC |-> $past(state_r) == S_DECODE)
    else $error("allocate commit without preceding decode");

  // Free check only after the last divide step
  a_free_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FREE |-> $past(state_r) == S_DIV && $past(sts.div_last))
    else $error("free check before divide finished");

endmodule

// ----- hw/rtl/fbp_dp.sv -----
// Datapath: config registers, list pointers, serial divider, link RAM, output register.
module fbp_dp import fbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fbp_cmd_t              cmd,
  output fbp_sts_t              sts,
  // request payload
  input  logic [1:0]            in_kind,
  input  logic [ADDR_W-1:0]     in_element_address,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [ADDR_W-1:0]     out_granted_address,
  output logic [CNT_W-1:0]      out_free_elements
);

  // Configuration
  logic [ADDR_W-1:0]   base_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [COUNT_W-1:0]  count_r;
  logic [CNT_W-1:0]    eff_count;

  // List state
  logic [IDX_W-1:0]    head_r;
  logic [IDX_W-1:0]    tail_r;
  logic [CNT_W-1:0]    free_r;

  // Transaction and working registers
  fbp_kind_t           kind_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [PROD_W-1:0]   prod_r;
  logic [ADDR_W-1:0]   quo_r;
  logic [STRIDE_W-1:0] rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [IDX_W-1:0]    rb_idx_r;
  fbp_status_t         res_status_r;
  logic [ADDR_W-1:0]   res_grant_r;

  // Output register
  logic                out_valid_r;
  fbp_status_t         out_status_r;
  logic [ADDR_W-1:0]   out_grant_r;
  logic [CNT_W-1:0]    out_free_r;

  // Link RAM
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]    ram_rdata;

  // Derived values
  logic                free_zero;
  logic                free_full;
  logic                free_gt1;
  logic                elem_ok;
  logic [IDX_W-1:0]    free_idx;
  logic                rb_last;
  logic [STRIDE_W:0]   div_trial;
  logic                div_fit;

  assign eff_count = (count_r > COUNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : CNT_W'(count_r);
  assign free_zero = (free_r == '0);
  assign free_full = (free_r == CNT_W'(POOL_DEPTH));
  assign free_gt1  = (free_r > CNT_W'(1));

  // Element check: quotient inside pool and no remainder
  assign elem_ok  = (quo_r[ADDR_W-1:CNT_W] == '0) && (quo_r[CNT_W-1:0] < eff_count) &&
                    (rem_r == '0);
  assign free_idx = quo_r[IDX_W-1:0];
  assign rb_last  = (CNT_W'(rb_idx_r) + CNT_W'(1)) >= eff_count;

  // Restoring divide step: one quotient bit per cycle
  assign div_trial = {rem_r, quo_r[ADDR_W-1]};
  assign div_fit   = div_trial >= {1'b0, stride_r};

  assign sts.kind      = kind_r;
  assign sts.free_zero = free_zero;
  assign sts.addr_bad  = (stride_r == '0) || (addr_r < base_r);
  assign sts.div_last  = (div_cnt_r == DIV_CNT_W'(ADDR_W - 1));
  assign sts.rb_last   = rb_last;
  assign sts.out_free  = !out_valid_r || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= BASE_RST;
      stride_r <= STRIDE_RST;
      count_r  <= COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE:   base_r   <= cfg_wdata[ADDR_W-1:0];
        REG_STRIDE: stride_r <= cfg_wdata[STRIDE_W-1:0];
        REG_COUNT:  count_r  <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Link writes: rebuild chain or tail append
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_wdata = free_idx;
    if (cmd.rb_step) begin
      ram_we    = !rb_last;
      ram_waddr = rb_idx_r;
      ram_wdata = rb_idx_r + IDX_W'(1);
    end else if (cmd.free_commit) begin
      ram_we = elem_ok && !free_full && !free_zero;
    end
  end

  fbp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (head_r),
    .rd_data (ram_rdata)
  );

  // List pointers and free count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      free_r <= '0;
    end else if (cmd.alloc_commit) begin
      if (free_gt1) begin
        head_r <= ram_rdata;
      end
      free_r <= free_r - CNT_W'(1);
    end else if (cmd.free_commit && elem_ok && !free_full) begin
      if (free_zero) begin
        head_r <= free_idx;
      end
      tail_r <= free_idx;
      free_r <= free_r + CNT_W'(1);
    end else if (cmd.rb_step && rb_last) begin
      head_r <= '0;
      tail_r <= (eff_count == '0) ? '0 : IDX_W'(eff_count - CNT_W'(1));
      free_r <= eff_count;
    end
  end

  // Transaction capture, multiplier, divider, rebuild counter
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= fbp_kind_t'(in_kind);
      addr_r <= in_element_address;
    end
    if (cmd.alloc_read) begin
      prod_r <= PROD_W'(head_r) * PROD_W'(stride_r);
    end
    if (cmd.div_start) begin
      quo_r     <= addr_r - base_r;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[ADDR_W-2:0], div_fit};
      rem_r     <= div_fit ? STRIDE_W'(div_trial - {1'b0, stride_r})
                           : div_trial[STRIDE_W-1:0];
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
    if (cmd.rb_start) begin
      rb_idx_r <= '0;
    end else if (cmd.rb_step && !rb_last) begin
      rb_idx_r <= rb_idx_r + IDX_W'(1);
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.res_empty) begin
      res_status_r <= ST_EMPTY;
      res_grant_r  <= '0;
    end else if (cmd.res_bad || (cmd.free_commit && !elem_ok)) begin
      res_status_r <= ST_NOT_ELEMENT;
      res_grant_r  <= '0;
    end else if (cmd.alloc_commit) begin
      res_status_r <= ST_OK;
      res_grant_r  <= base_r + ADDR_W'(prod_r);
    end else if (cmd.res_ok || cmd.free_commit || cmd.rb_step) begin
      res_status_r <= ST_OK;
      res_grant_r  <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_grant_r  <= res_grant_r;
      out_free_r   <= free_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_grant_r;
  assign out_free_elements   = out_free_r;

  // Free count never exceeds pool depth
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CNT_W'(POOL_DEPTH))
    else $error("free count above pool depth");

  // Allocate only commits on a non-empty list
  a_alloc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_commit |-> !free_zero)
    else $error("allocate from empty list");

  // Rebuild leaves the whole pool free
  a_rebuild_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rb_step && rb_last |=> free_r == eff_count)
    else $error("rebuild free count mismatch");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_ready)
    else $error("result register overwritten");

endmodule

// ----- hw/rtl/fifo_free_list_buffer_pool.sv -----
// Top level of the FIFO free-list buffer pool.
//
// Manages pool_count equal elements placed from base_address at element_stride
// bytes apart. Requests arrive on in_ch (kind, element_address), one result per
// request leaves on out_ch (status, granted_address, free_elements); both use
// valid/ready and a transaction completes when both are high at a clock edge.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while idle, which the block does not enforce.
// One request is processed at a time:
//   allocate: head read in decode, then commit (skipped if the pool is empty),
//   free: a 32-step serial divide of the address offset by the stride, then
//         the element check (no divide when the address is below base or
//         stride is 0),
//   rebuild: one link write per element of min(pool_count, 256) but the last,
//   unused kind: result straight from decode.
// in_ch.ready rises again the cycle after a result is loaded into the output
// register, so a new request can be taken while that result waits on a
// stalled receiver; the next result then waits until the register is free.
// Reset empties the list (no free elements) and loads base 0, stride 8 and
// count 256. The link RAM is not cleared; rebuild or frees fill it.
module fifo_free_list_buffer_pool import fbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  fbp_in_if.sink                in_ch,
  fbp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  fbp_cmd_t cmd;
  fbp_sts_t sts;

  fbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbp_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_kind             (in_ch.kind),
    .in_element_address  (in_ch.element_address),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_status          (out_ch.status),
    .out_granted_address (out_ch.granted_address),
    .out_free_elements   (out_ch.free_elements)
  );

endmodule
